### design/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg: shared types and constants for the box frustum cull core
// Holds the sequencer states, request codes, result classes and
// register offsets used by the core.
// ----------------------------------------------------------------------------
package bfc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EVAL,
    ST_DONE
  } bfc_state_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  localparam logic [1:0] CLASS_OUT  = 2'd0;
  localparam logic [1:0] CLASS_IN   = 2'd1;
  localparam logic [1:0] CLASS_PART = 2'd2;

  localparam logic REG_NUM_PLANES = 1'b0;

  localparam int unsigned ACC_W = 68;
  localparam logic [2:0] LAST_STEP = 3'd6;

endpackage

### design/box_frustum_cull_core.sv
// ----------------------------------------------------------------------------
// box_frustum_cull_core: axis-aligned box versus plane set classifier
// Stores up to MAX_PLANES clipping planes and classifies boxes as outside,
// fully inside or partially inside, using exact Q32.32 products.
// ----------------------------------------------------------------------------
// A plane load beat writes the plane table and gives no result. A box test
// beat works through each active plane in turn and then hands the result
// to the output register; the next beat can be taken once the result is in
// the output register. The test stops early at the first plane that rejects
// the box, and a stalled result holds the input side off until it is taken.
// Each plane is worked by a single shared 32x32 multiplier that forms the
// six products of the plane one per cycle into a product register, with a
// further step that adds the last product and an evaluation state that adds
// and compares the two wide sums.
// The input side stalls while a box is in work.
module box_frustum_cull_core
  import bfc_pkg::*;
#(
  parameter int MAX_PLANES = 6
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [2:0]         in_plane_index,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  input  logic signed [31:0] in_plane_offset,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic signed [31:0] in_extent_x,
  input  logic signed [31:0] in_extent_y,
  input  logic signed [31:0] in_extent_z,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_cull_class,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int CW = $clog2(MAX_PLANES + 1);

  logic signed [31:0] nx_tab [MAX_PLANES];
  logic signed [31:0] ny_tab [MAX_PLANES];
  logic signed [31:0] nz_tab [MAX_PLANES];
  logic signed [31:0] off_tab [MAX_PLANES];

  bfc_state_t state_r, state_nxt;
  logic [2:0]  num_planes_r;
  logic [2:0]  step_r, step_nxt;
  logic [CW-1:0] pl_r, pl_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic        all_in_r, all_in_nxt;
  logic signed [ACC_W-1:0] dist_r, dist_nxt;
  logic signed [ACC_W-1:0] rad_r, rad_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic        prod_rad_r, prod_rad_nxt;
  logic [1:0]  res_class_r, res_class_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_class_r, out_class_nxt;

  logic signed [31:0] cx_r, cy_r, cz_r, ex_r, ey_r, ez_r;

  logic              in_acc;
  logic              cfg_wr;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     wr_idx;
  logic              wr_ok;
  logic [CW-1:0]     n_clamp;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [63:0]        prod_abs;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] off_ext;
  logic signed [ACC_W-1:0] sum_s, sum_t;
  logic [CW-1:0]     pl_inc;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_NUM_PLANES) ? {29'd0, num_planes_r} : 32'd0;

  assign out_valid      = out_valid_r;
  assign out_cull_class = out_class_r;

  assign rd_idx  = pl_r[IW-1:0];
  assign wr_idx  = IW'(in_plane_index);
  assign wr_ok   = ({29'd0, in_plane_index} < 32'(MAX_PLANES));
  assign n_clamp = (32'(num_planes_r) > 32'(MAX_PLANES)) ? CW'(MAX_PLANES)
                                                          : CW'(num_planes_r);
  assign pl_inc  = pl_r + CW'(1);

  always_comb begin
    unique case (step_r)
      3'd0: begin
        mul_a = nx_tab[rd_idx];
        mul_b = ex_r;
      end
      3'd1: begin
        mul_a = ny_tab[rd_idx];
        mul_b = ey_r;
      end
      3'd2: begin
        mul_a = nz_tab[rd_idx];
        mul_b = ez_r;
      end
      3'd3: begin
        mul_a = nx_tab[rd_idx];
        mul_b = cx_r;
      end
      3'd4: begin
        mul_a = ny_tab[rd_idx];
        mul_b = cy_r;
      end
      3'd5: begin
        mul_a = nz_tab[rd_idx];
        mul_b = cz_r;
      end
      default: begin
        mul_a = nx_tab[rd_idx];
        mul_b = cx_r;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_abs = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign prod_ext = prod_rad_r ? $signed({4'd0, prod_abs})
                               : $signed({{4{prod_r[63]}}, prod_r});
  assign off_ext  = $signed({{20{off_tab[rd_idx][31]}}, off_tab[rd_idx], 16'd0});
  assign sum_s    = dist_r + rad_r;
  assign sum_t    = dist_r - rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_planes_r <= 3'd6;
      out_valid_r  <= 1'b0;
      step_r       <= 3'd0;
      pl_r         <= '0;
      n_r          <= '0;
      all_in_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      pl_r        <= pl_nxt;
      n_r         <= n_nxt;
      all_in_r    <= all_in_nxt;
      if (cfg_wr && (paddr[2] == REG_NUM_PLANES)) begin
        num_planes_r <= pwdata[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r      <= dist_nxt;
    rad_r       <= rad_nxt;
    prod_r      <= prod_nxt;
    prod_rad_r  <= prod_rad_nxt;
    res_class_r <= res_class_nxt;
    out_class_r <= out_class_nxt;
    if (in_acc && (in_req_type == REQ_TEST)) begin
      cx_r <= in_centre_x;
      cy_r <= in_centre_y;
      cz_r <= in_centre_z;
      ex_r <= in_extent_x;
      ey_r <= in_extent_y;
      ez_r <= in_extent_z;
    end
    if (in_acc && (in_req_type == REQ_LOAD) && wr_ok) begin
      nx_tab[wr_idx]  <= in_normal_x;
      ny_tab[wr_idx]  <= in_normal_y;
      nz_tab[wr_idx]  <= in_normal_z;
      off_tab[wr_idx] <= in_plane_offset;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pl_nxt        = pl_r;
    n_nxt         = n_r;
    all_in_nxt    = all_in_r;
    dist_nxt      = dist_r;
    rad_nxt       = rad_r;
    prod_nxt      = prod_r;
    prod_rad_nxt  = prod_rad_r;
    res_class_nxt = res_class_r;
    out_class_nxt = out_class_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req_type == REQ_TEST)) begin
          pl_nxt     = '0;
          step_nxt   = 3'd0;
          n_nxt      = n_clamp;
          all_in_nxt = 1'b1;
          if (n_clamp == '0) begin
            res_class_nxt = CLASS_PART;
            state_nxt     = ST_DONE;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (step_r == 3'd0) begin
          dist_nxt = off_ext;
          rad_nxt  = '0;
        end else if (prod_rad_r) begin
          rad_nxt = rad_r + prod_ext;
        end else begin
          dist_nxt = dist_r + prod_ext;
        end
        prod_nxt     = mul_p;
        prod_rad_nxt = (step_r < 3'd3);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_EVAL;
          step_nxt  = 3'd0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_EVAL: begin
        if (sum_s[ACC_W-1] || (sum_s == '0)) begin
          res_class_nxt = CLASS_OUT;
          state_nxt     = ST_DONE;
        end else begin
          if (sum_t[ACC_W-1]) begin
            all_in_nxt = 1'b0;
          end
          if (pl_inc == n_r) begin
            res_class_nxt = (all_in_r && !sum_t[ACC_W-1]) ? CLASS_IN : CLASS_PART;
            state_nxt     = ST_DONE;
          end else begin
            pl_nxt    = pl_inc;
            step_nxt  = 3'd0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = res_class_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
